[rtl/core/sobol_pkg.sv]
// ----------------------------------------------------------------------------
// sobol_pkg
// Shared constants, types and helpers of the Sobol sequence generator.
// ----------------------------------------------------------------------------
package sobol_pkg;

  localparam int unsigned FracBits  = 32;
  localparam int unsigned MaxDegree = 18;
  localparam int unsigned TabDepth  = 32;
  localparam int unsigned TabAw     = $clog2(TabDepth);
  localparam int unsigned DegW      = 5;
  localparam int unsigned PolyW     = 17;
  localparam int unsigned MValW     = 18;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_PREP = 2'd1;
  localparam logic [1:0] OP_NEXT = 2'd2;

  localparam logic [1:0] CFG_DEGREE    = 2'd0;
  localparam logic [1:0] CFG_POLY_BITS = 2'd1;
  localparam logic [1:0] CFG_FIRST_DIM = 2'd2;

  typedef struct packed {
    logic                we;
    logic [TabAw-1:0]    waddr;
    logic [FracBits-1:0] wdata;
    logic [TabAw-1:0]    raddr;
  } mem_req_t;

  function automatic logic [DegW-1:0] eff_degree(input logic [DegW-1:0] deg);
    logic [DegW-1:0] res;
    res = deg;
    if (deg == '0) begin
      res = DegW'(1);
    end else if (deg > DegW'(MaxDegree)) begin
      res = DegW'(MaxDegree);
    end
    return res;
  endfunction

endpackage

[rtl/core/sobol_dir_ram.sv]
// ----------------------------------------------------------------------------
// sobol_dir_ram
// Direction number memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sobol_dir_ram
  import sobol_pkg::*;
(
  input  logic                clk_i,
  input  mem_req_t            req_i,
  output logic [FracBits-1:0] rdata_o
);

  logic [FracBits-1:0] mem_q [TabDepth];
  logic [FracBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/sobol_prep.sv]
// ----------------------------------------------------------------------------
// sobol_prep
// Table builder: fills the direction table with single-bit values (all m = 1) or extends
// the loaded entries by the primitive-polynomial recurrence.
// ----------------------------------------------------------------------------
module sobol_prep
  import sobol_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DegW-1:0]     degree_i,
  input  logic [PolyW-1:0]    poly_i,
  input  logic                first_dim_i,
  input  logic [FracBits-1:0] rdata_i,
  output logic                busy_o,
  output mem_req_t            req_o
);

  typedef enum logic [1:0] {
    P_IDLE,
    P_ONES,
    P_READ,
    P_WRITE
  } prep_state_e;

  prep_state_e         state_q, state_d;
  logic [DegW-1:0]     s_q, s_d;
  logic [PolyW-1:0]    poly_q, poly_d;
  logic [TabAw:0]      i_q, i_d;
  logic [DegW-1:0]     k_q, k_d;
  logic [FracBits-1:0] acc_q, acc_d;

  logic [DegW-1:0]     kd;
  logic [DegW-1:0]     pidx;
  logic [PolyW-1:0]    poly_sh;
  logic [FracBits-1:0] acc_new;
  logic [TabAw:0]      rd_entry;
  logic [TabAw:0]      wr_entry;

  always_comb begin
    kd      = (state_q == P_WRITE) ? DegW'(1) : k_q + DegW'(1);
    pidx    = s_q - DegW'(1) - kd;
    poly_sh = poly_q >> pidx;
    if (kd == s_q) begin
      acc_new = rdata_i ^ (rdata_i >> s_q);
    end else if (poly_sh[0]) begin
      acc_new = acc_q ^ rdata_i;
    end else begin
      acc_new = acc_q;
    end
  end

  assign rd_entry = i_q - (TabAw+1)'(k_q) - (TabAw+1)'(1);
  assign wr_entry = i_q - (TabAw+1)'(1);

  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    poly_d      = poly_q;
    i_d         = i_q;
    k_d         = k_q;
    acc_d       = acc_q;
    req_o.we    = 1'b0;
    req_o.waddr = wr_entry[TabAw-1:0];
    req_o.wdata = acc_new;
    req_o.raddr = rd_entry[TabAw-1:0];
    unique case (state_q)
      P_IDLE: begin
        if (start_i) begin
          s_d    = eff_degree(degree_i);
          poly_d = poly_i;
          k_d    = eff_degree(degree_i);
          if (first_dim_i) begin
            i_d     = '0;
            state_d = P_ONES;
          end else begin
            i_d     = (TabAw+1)'(eff_degree(degree_i)) + (TabAw+1)'(1);
            state_d = P_READ;
          end
        end
      end
      P_ONES: begin
        req_o.we    = 1'b1;
        req_o.waddr = i_q[TabAw-1:0];
        req_o.wdata = {1'b1, {(FracBits-1){1'b0}}} >> i_q[TabAw-1:0];
        i_d         = i_q + (TabAw+1)'(1);
        if (i_q[TabAw-1:0] == TabAw'(TabDepth - 1)) begin
          state_d = P_IDLE;
        end
      end
      P_READ: begin
        if (k_q != s_q) begin
          acc_d = acc_new;
        end
        if (k_q == DegW'(1)) begin
          state_d = P_WRITE;
        end else begin
          k_d = k_q - DegW'(1);
        end
      end
      P_WRITE: begin
        req_o.we = 1'b1;
        acc_d    = acc_new;
        k_d      = s_q;
        if (i_q == (TabAw+1)'(FracBits)) begin
          state_d = P_IDLE;
        end else begin
          i_d     = i_q + (TabAw+1)'(1);
          state_d = P_READ;
        end
      end
      default: state_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    poly_q <= poly_d;
    i_q    <= i_d;
    k_q    <= k_d;
    acc_q  <= acc_d;
  end

  assign busy_o = (state_q != P_IDLE);

endmodule

[rtl/core/sobol_sequence_generator.sv]
// ----------------------------------------------------------------------------
// sobol_sequence_generator
// One dimension of a Sobol sequence in Gray-code order, table in memory.
// ----------------------------------------------------------------------------
// channel   | dir | handshake               | payload
// s_axis    | in  | s_axis_tvalid/tready    | tuser opcode, tdata m_index, m_value
// m_axis    | out | m_axis_tvalid/tready    | tdata point, point_number; tuser exhausted
// cfg       | in  | cfg_we                  | cfg_addr, cfg_wdata
//
// Load request: one table write.
// Next request: a table read then the XOR into the point.
// Prepare request: fills every table entry for the first dimension, else builds
//   entries s+1..32 one at a time through the single read port, s the degree.
// Reset clears control state only; the table is undefined until written.
// A next request waits while the result register is full and not taken.
// ----------------------------------------------------------------------------
module sobol_sequence_generator
  import sobol_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [23:0]           s_axis_tdata_i,   // m_index[4:0], m_value[22:5]
  input  logic [1:0]            s_axis_tuser_i,   // opcode[1:0]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [2*FracBits-1:0] m_axis_tdata_o,   // point[31:0], point_number[63:32]
  output logic                  m_axis_tuser_o,   // exhausted[0]
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_addr_i,
  input  logic [PolyW-1:0]      cfg_wdata_i
);

  typedef enum logic {
    ST_IDLE,
    ST_ADVANCE
  } top_state_e;

  top_state_e          state_q, state_d;
  logic [DegW-1:0]     deg_q, deg_d;
  logic [PolyW-1:0]    poly_q, poly_d;
  logic                first_q, first_d;
  logic [FracBits-1:0] point_q, point_d;
  logic [FracBits-1:0] counter_q, counter_d;
  logic                done_q, done_d;
  logic                m_valid_q, m_valid_d;
  logic [FracBits-1:0] out_point_q, out_point_d;
  logic [FracBits-1:0] out_num_q, out_num_d;
  logic                out_exh_q, out_exh_d;

  logic [1:0]              opcode;
  logic [DegW-1:0]         m_index;
  logic [MValW-1:0]        m_value;
  logic                    in_acc;
  logic                    out_room;
  logic                    prep_busy;
  logic                    prep_start;
  logic [MValW+FracBits-1:0] ld_shift;
  logic                    ld_ok;
  logic [TabAw-1:0]        next_addr;
  logic [FracBits-1:0]     rdata;
  mem_req_t                prep_req;
  mem_req_t                top_req;
  mem_req_t                ram_req;

  function automatic logic [TabAw-1:0] lowest_zero(input logic [FracBits-1:0] v);
    logic [TabAw-1:0] pos;
    pos = '0;
    for (int b = FracBits - 1; b >= 0; b--) begin
      if (!v[b]) begin
        pos = TabAw'(b);
      end
    end
    return pos;
  endfunction

  assign opcode  = s_axis_tuser_i;
  assign m_index = s_axis_tdata_i[DegW-1:0];
  assign m_value = s_axis_tdata_i[DegW+MValW-1:DegW];

  assign out_room        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && !prep_busy &&
                           ((opcode != OP_NEXT) || out_room);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign prep_start      = in_acc && (opcode == OP_PREP);

  assign ld_shift  = {m_value, {FracBits{1'b0}}} >> m_index;
  assign ld_ok     = (m_index != '0) && (m_index <= eff_degree(deg_q));
  assign next_addr = lowest_zero(counter_q);

  always_comb begin
    top_req.we    = in_acc && (opcode == OP_LOAD) && ld_ok;
    top_req.waddr = TabAw'(m_index - DegW'(1));
    top_req.wdata = ld_shift[FracBits-1:0];
    top_req.raddr = next_addr;
    ram_req       = prep_busy ? prep_req : top_req;
  end

  always_comb begin
    state_d     = state_q;
    deg_d       = deg_q;
    poly_d      = poly_q;
    first_d     = first_q;
    point_d     = point_q;
    counter_d   = counter_q;
    done_d      = done_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    out_point_d = out_point_q;
    out_num_d   = out_num_q;
    out_exh_d   = out_exh_q;

    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_DEGREE:    deg_d   = cfg_wdata_i[DegW-1:0];
        CFG_POLY_BITS: poly_d  = cfg_wdata_i;
        CFG_FIRST_DIM: first_d = cfg_wdata_i[0];
        default:       ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (opcode == OP_PREP)) begin
          point_d   = '0;
          counter_d = '0;
          done_d    = 1'b0;
        end else if (in_acc && (opcode == OP_NEXT)) begin
          m_valid_d   = 1'b1;
          out_point_d = point_q;
          out_num_d   = counter_q;
          out_exh_d   = done_q;
          if (!done_q) begin
            if (&counter_q) begin
              done_d = 1'b1;
            end else begin
              state_d = ST_ADVANCE;
            end
          end
        end
      end
      ST_ADVANCE: begin
        point_d   = point_q ^ rdata;
        counter_d = counter_q + FracBits'(1);
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      deg_q     <= DegW'(1);
      poly_q    <= '0;
      first_q   <= 1'b1;
      point_q   <= '0;
      counter_q <= '0;
      done_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      deg_q     <= deg_d;
      poly_q    <= poly_d;
      first_q   <= first_d;
      point_q   <= point_d;
      counter_q <= counter_d;
      done_q    <= done_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_point_q <= out_point_d;
    out_num_q   <= out_num_d;
    out_exh_q   <= out_exh_d;
  end

  sobol_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (prep_start),
    .degree_i    (deg_q),
    .poly_i      (poly_q),
    .first_dim_i (first_q),
    .rdata_i     (rdata),
    .busy_o      (prep_busy),
    .req_o       (prep_req)
  );

  sobol_dir_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {out_num_q, out_point_q};
  assign m_axis_tuser_o  = out_exh_q;

  a_no_accept_in_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prep_busy |-> !in_acc)
    else $error("request accepted while table is being built");

  a_done_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (&counter_q))
    else $error("exhausted flag set before last point");

  a_advance_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADVANCE) |=> (counter_q == $past(counter_q) + FracBits'(1)))
    else $error("point counter did not advance");

  a_advance_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADVANCE) |-> m_valid_q)
    else $error("advance without a pending result");

endmodule

[verif/tb_sobol_sequence_generator.sv]
// ----------------------------------------------------------------------------
// tb_sobol_sequence_generator
// Streams load, prepare and next requests into the generator and checks each
// point, point number and exhausted flag against a cycle-free predictor that
// keeps its own direction table. Both stream sides idle at random, and the
// configuration is changed between phases only while the block is idle.
// ----------------------------------------------------------------------------
module tb_sobol_sequence_generator;
  import sobol_pkg::*;

  localparam logic [1:0] OpUnused     = 2'd3;
  localparam int unsigned SettleCycles = 300;  // outlasts the longest prepare request
  localparam int unsigned TargetItems  = 1700;

  typedef struct packed {
    logic [FracBits-1:0] point;
    logic [31:0]         number;
    logic                exhausted;
  } sobol_point_t;

  class sobol_point_tracker;
    logic [DegW-1:0]     degree    = DegW'(1);
    logic [PolyW-1:0]    poly_bits = '0;
    logic                first_dim = 1'b1;
    logic [FracBits-1:0] directions [TabDepth];
    logic [FracBits-1:0] point     = '0;
    logic [31:0]         counter   = '0;
    logic                done      = 1'b0;
    sobol_point_t        pending_points [$];
    int unsigned         errors    = 0;

    function void set_register(logic [1:0] addr, logic [PolyW-1:0] value);
      case (addr)
        CFG_DEGREE:    degree    = value[DegW-1:0];
        CFG_POLY_BITS: poly_bits = value;
        CFG_FIRST_DIM: first_dim = value[0];
        default: ;
      endcase
    endfunction

    function int unsigned effective_degree();
      if (degree == '0) return 1;
      if (degree > DegW'(MaxDegree)) return MaxDegree;
      return int'(degree);
    endfunction

    function void rebuild_table();
      int unsigned s;
      int unsigned i;
      int unsigned k;
      logic [FracBits-1:0] base;
      logic [FracBits-1:0] v;
      s = effective_degree();
      if (first_dim) begin
        for (i = 1; i <= FracBits; i++) directions[i-1] = 32'h1 << (32 - i);
      end else begin
        for (i = s + 1; i <= FracBits; i++) begin
          base = directions[i-s-1];
          v = base ^ (base >> s);
          for (k = 1; k < s; k++) begin
            if (poly_bits[s-1-k]) v ^= directions[i-k-1];
          end
          directions[i-1] = v;
        end
      end
    endfunction

    // Returns 1 when the request has an effect on the block.
    function bit apply_request(logic [1:0] op, logic [4:0] idx, logic [MValW-1:0] mval);
      logic [63:0]  wide;
      logic [31:0]  v;
      int unsigned  c;
      sobol_point_t r;
      case (op)
        OP_LOAD: begin
          if (idx >= 5'd1 && int'(idx) <= effective_degree()) begin
            wide = 64'(mval) << (32 - int'(idx));
            directions[idx-1] = wide[31:0];
            return 1'b1;
          end
        end
        OP_PREP: begin
          rebuild_table();
          point   = '0;
          counter = '0;
          done    = 1'b0;
          return 1'b1;
        end
        OP_NEXT: begin
          r.point     = point;
          r.number    = counter;
          r.exhausted = done;
          pending_points.push_back(r);
          if (!done) begin
            if (counter == '1) begin
              done = 1'b1;
            end else begin
              c = 1;
              v = counter;
              while (v[0]) begin
                v = v >> 1;
                c++;
              end
              point ^= directions[c-1];
              counter++;
            end
          end
          return 1'b1;
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    task report(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      errors++;
    endtask

    task check_point(logic [FracBits-1:0] p, logic [31:0] n, logic ex);
      sobol_point_t r;
      if (pending_points.size() == 0) begin
        report("unrequested point", '0, p);
        return;
      end
      r = pending_points.pop_front();
      if (p !== r.point)      report("point", r.point, p);
      if (n !== r.number)     report("point_number", r.number, n);
      if (ex !== r.exhausted) report("exhausted", 32'(r.exhausted), 32'(ex));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [23:0]           s_axis_tdata_i;   // m_index[4:0], m_value[22:5]
  logic [1:0]            s_axis_tuser_i;   // opcode[1:0]
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [2*FracBits-1:0] m_axis_tdata_o;   // point[31:0], point_number[63:32]
  logic                  m_axis_tuser_o;   // exhausted[0]
  logic                  cfg_we_i;
  logic [1:0]            cfg_addr_i;
  logic [PolyW-1:0]      cfg_wdata_i;

  sobol_point_tracker tracker = new;
  bit          steady = 1'b0;
  int unsigned sent_items = 0;

  sobol_sequence_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic send_request(logic [1:0] op, logic [4:0] idx, logic [MValW-1:0] mval);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, mval, idx};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (tracker.apply_request(op, idx, mval)) sent_items++;
  endtask

  task automatic send_noise();
    send_request(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), MValW'($urandom));
  endtask

  task automatic send_next();
    send_request(OP_NEXT, 5'($urandom), MValW'($urandom));
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.pending_points.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic configure(logic [DegW-1:0] deg, logic [PolyW-1:0] poly, logic first);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_DEGREE;
    cfg_wdata_i <= PolyW'(deg);
    @(posedge clk_i);
    tracker.set_register(CFG_DEGREE, PolyW'(deg));
    cfg_addr_i  <= CFG_POLY_BITS;
    cfg_wdata_i <= poly;
    @(posedge clk_i);
    tracker.set_register(CFG_POLY_BITS, poly);
    cfg_addr_i  <= CFG_FIRST_DIM;
    cfg_wdata_i <= PolyW'(first);
    @(posedge clk_i);
    tracker.set_register(CFG_FIRST_DIM, PolyW'(first));
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int unsigned phase_no);
    logic [DegW-1:0]  deg;
    logic [PolyW-1:0] poly;
    logic             first;
    logic [MValW-1:0] mask;
    int unsigned      s;
    int unsigned      runs;
    int unsigned      i;
    poly  = PolyW'($urandom);
    first = 1'b0;
    case (phase_no)
      0: begin
        deg  = DegW'(1);
        poly = '0;
      end
      1: begin
        deg  = DegW'(MaxDegree);
        poly = '1;
      end
      2: deg = '0;
      3: begin
        deg   = '1;
        first = 1'b1;
      end
      default: begin
        deg   = DegW'($urandom_range(0, 31));
        first = ($urandom_range(0, 4) == 0);
      end
    endcase
    drain();
    steady = ($urandom_range(0, 3) == 0);
    configure(deg, poly, first);
    s = tracker.effective_degree();
    for (i = 1; i <= s; i++) begin
      mask = MValW'((32'd1 << i) - 1);
      if ($urandom_range(0, 9) != 0) begin
        send_request(OP_LOAD, 5'(i), (MValW'($urandom) & mask) | MValW'(1));
      end
      if ($urandom_range(0, 19) == 0) send_noise();
    end
    send_request(OP_PREP, 5'($urandom), MValW'($urandom));
    runs = ($urandom_range(0, 5) == 0) ? $urandom_range(300, 600) : $urandom_range(10, 100);
    for (i = 0; i < runs; i++) begin
      if ($urandom_range(0, 19) == 0) send_noise();
      else send_next();
    end
  endtask

  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      tracker.check_point(m_axis_tdata_o[31:0], m_axis_tdata_o[63:32], m_axis_tuser_o);
    end
  end

  initial begin
    int unsigned phase_no;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_LOAD;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = CFG_DEGREE;
    cfg_wdata_i     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First dimension after reset: fill the whole table before any next request
    send_request(OP_PREP, '0, '0);
    send_request(OP_NEXT, '1, '1);
    send_next();
    send_next();
    send_request(OpUnused, '1, '1);
    send_request(OP_LOAD, 5'd1, '1);
    send_request(OP_PREP, '1, '1);
    send_next();
    send_next();

    // Saturated degree, full polynomial and out-of-range loads
    drain();
    configure('1, '1, 1'b0);
    send_request(OP_LOAD, 5'd0, '1);
    send_request(OP_LOAD, 5'd19, '1);
    send_request(OP_LOAD, 5'd31, '1);
    send_request(OP_LOAD, 5'd18, '1);
    send_request(OP_LOAD, 5'd1, MValW'(1));
    send_request(OP_PREP, '0, '0);
    repeat (4) send_next();

    phase_no = 0;
    while (sent_items < TargetItems) begin
      run_phase(phase_no);
      phase_no++;
    end

    drain();
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
rtl/core/sobol_pkg.sv
rtl/core/sobol_dir_ram.sv
rtl/core/sobol_prep.sv
rtl/core/sobol_sequence_generator.sv
verif/tb_sobol_sequence_generator.sv
